// ----- hdl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent check macros, sampled on clk, quiet while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define CHK_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// expression must always hold
`define CHK_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error(msg);

`endif

// ----- hdl/id3fh_pkg.sv -----
// ----------------------------------------------------------------------------
// id3fh_pkg
// Shared types and constants of the ID3v2 frame header parser.
// ----------------------------------------------------------------------------
`default_nettype none

package id3fh_pkg;

  localparam logic [2:0] VER_22    = 3'd2;
  localparam logic [2:0] VER_23    = 3'd3;
  localparam logic [2:0] VER_24    = 3'd4;
  localparam logic [2:0] VER_RESET = VER_23;

  localparam logic [4:0] FULL_ID_LEN = 5'd4;
  localparam logic [4:0] FIXED_LEN   = 5'd10;
  localparam logic [4:0] MAX_HDR_LEN = 5'd16;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_ID_TRUNC   = 3'd1,
    ST_ZERO_SIZE  = 3'd2,
    ST_FLAG_TRUNC = 3'd3,
    ST_OPT_TRUNC  = 3'd4
  } status_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_of_header;
    logic       buffer_end;
  } item_t;

  typedef struct packed {
    logic [31:0] frame_id;
    logic [31:0] content_size;
    logic        tag_alter;
    logic        file_alter;
    logic        read_only;
    logic        unsync;
    logic [31:0] decompression_size;
    logic [7:0]  encryption_symbol;
    logic [7:0]  group_symbol;
    logic [4:0]  bytes_consumed;
    status_t     status;
  } result_t;

  typedef struct packed {
    logic [4:0] byte_pos;
    logic       done;
  } core_stat_t;

  // optional field offsets and lengths after the fixed 10-byte header
  typedef struct packed {
    logic [4:0] od;
    logic [4:0] dl;
    logic [4:0] oe;
    logic [4:0] el;
    logic [4:0] og;
    logic [4:0] gl;
    logic [4:0] total;
  } plan_t;

  function automatic plan_t plan_of(input logic [2:0] lay, input logic [7:0] f1);
    plan_t p;
    p = '0;
    if (lay == VER_23) begin
      p.dl = f1[7] ? 5'd4 : 5'd0;
      p.el = f1[6] ? 5'd1 : 5'd0;
      p.gl = f1[5] ? 5'd1 : 5'd0;
      p.od = 5'd0;
      p.oe = p.dl;
      p.og = p.dl + p.el;
    end else begin
      p.gl = f1[6] ? 5'd1 : 5'd0;
      p.el = f1[2] ? 5'd1 : 5'd0;
      p.dl = f1[0] ? 5'd4 : 5'd0;
      p.og = 5'd0;
      p.oe = p.gl;
      p.od = p.gl + p.el;
    end
    p.total = p.dl + p.el + p.gl;
    return p;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/id3fh_in_stage.sv -----
// ----------------------------------------------------------------------------
// id3fh_in_stage
// Input register; holds one request until the parse stage takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module id3fh_in_stage
  import id3fh_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  in_valid,
  output logic       in_stall,
  input  wire item_t in_item,
  input  wire logic  adv,
  output logic       s1_valid,
  output item_t      s1_item
);

  logic  s1_valid_r;
  item_t s1_item_r;

  assign in_stall = s1_valid_r & ~adv;
  assign s1_valid = s1_valid_r;
  assign s1_item  = s1_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_item_r <= in_item;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/id3fh_core.sv -----
// ----------------------------------------------------------------------------
// id3fh_core
// Parse state, version register and single-pass byte update / result build.
// ----------------------------------------------------------------------------
`default_nettype none

module id3fh_core
  import id3fh_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_wr_en,
  input  wire logic [2:0] cfg_wr_data,
  input  wire logic       fire,
  input  wire item_t      item,
  output logic            res_valid,
  output result_t         res,
  output core_stat_t      stat
);

  logic [4:0]  pos_r;
  logic        done_r;
  logic [2:0]  lay_r;
  logic [2:0]  ver_r;
  logic [31:0] id_r, size_r, opt_r;
  logic [15:0] flag_r;
  logic [7:0]  enc_r, grp_r;

  logic [4:0]  pos0, n, idl, idl2, k, nx, start;
  logic        done0, hit;
  logic [2:0]  lay;
  logic [31:0] id0, size0, opt0, id_nxt, size_nxt, opt_nxt;
  logic [15:0] flag0, flag_nxt;
  logic [7:0]  enc0, grp0, enc_nxt, grp_nxt, b;
  plan_t       pl0, pl;
  result_t     r;

  always_comb begin
    b     = item.data_byte;
    pos0  = item.start_of_header ? 5'd0  : pos_r;
    id0   = item.start_of_header ? 32'd0 : id_r;
    size0 = item.start_of_header ? 32'd0 : size_r;
    flag0 = item.start_of_header ? 16'd0 : flag_r;
    opt0  = item.start_of_header ? 32'd0 : opt_r;
    enc0  = item.start_of_header ? 8'd0  : enc_r;
    grp0  = item.start_of_header ? 8'd0  : grp_r;
    lay   = item.start_of_header ? ver_r : lay_r;
    done0 = item.start_of_header ? (ver_r < VER_22 || ver_r > VER_24) : done_r;

    n    = pos0 + 5'd1;
    idl  = (lay == VER_22) ? FULL_ID_LEN - 5'd1 : FULL_ID_LEN;
    idl2 = {idl[3:0], 1'b0};
    k    = n - FIXED_LEN - 5'd1;
    nx   = n - FIXED_LEN;

    id_nxt   = id0;
    size_nxt = size0;
    flag_nxt = flag0;
    opt_nxt  = opt0;
    enc_nxt  = enc0;
    grp_nxt  = grp0;
    pl0      = plan_of(lay, flag0[7:0]);

    if (n <= idl) begin
      id_nxt = {id0[23:0], b};
    end else if (n <= idl2) begin
      size_nxt = (lay == VER_24) ? {size0[24:0], b[6:0]} : {size0[23:0], b};
    end else if (n <= FIXED_LEN) begin
      flag_nxt = {flag0[7:0], b};
    end else begin
      if (pl0.dl != 5'd0 && k >= pl0.od && k < pl0.od + pl0.dl) begin
        opt_nxt = (lay == VER_24) ? {opt0[24:0], b[6:0]} : {opt0[23:0], b};
      end
      if (pl0.el != 5'd0 && k == pl0.oe) begin
        enc_nxt = b;
      end
      if (pl0.gl != 5'd0 && k == pl0.og) begin
        grp_nxt = b;
      end
    end

    pl    = plan_of(lay, flag_nxt[7:0]);
    start = (pl.dl != 5'd0 && nx >= pl.od && nx < pl.od + pl.dl) ? pl.od : nx;

    r   = '0;
    hit = 1'b1;
    if (n == idl2 && size_nxt == 32'd0) begin
      r.status = ST_ZERO_SIZE;
      if (lay == VER_22) begin
        r.frame_id       = id_nxt;
        r.bytes_consumed = idl2;
      end else begin
        r.bytes_consumed = idl;
      end
    end else if (n == idl2 && lay == VER_22) begin
      r.frame_id       = id_nxt;
      r.content_size   = size_nxt;
      r.bytes_consumed = idl2;
      r.status         = ST_OK;
    end else if (n >= FIXED_LEN && n == FIXED_LEN + pl.total) begin
      r.frame_id           = id_nxt;
      r.content_size       = size_nxt;
      r.decompression_size = opt_nxt;
      r.encryption_symbol  = enc_nxt;
      r.group_symbol       = grp_nxt;
      r.bytes_consumed     = n;
      r.status             = ST_OK;
    end else if (item.buffer_end) begin
      if (n < idl) begin
        r.status = ST_ID_TRUNC;
      end else if (n < idl2) begin
        r.status         = ST_ID_TRUNC;
        r.bytes_consumed = idl;
      end else if (n < FIXED_LEN) begin
        r.status         = ST_FLAG_TRUNC;
        r.content_size   = size_nxt;
        r.bytes_consumed = idl2;
      end else begin
        r.status       = ST_OPT_TRUNC;
        r.frame_id     = id_nxt;
        r.content_size = size_nxt;
        if (pl.dl != 5'd0 && pl.od + pl.dl <= nx) r.decompression_size = opt_nxt;
        if (pl.el != 5'd0 && pl.oe + 5'd1 <= nx)  r.encryption_symbol  = enc_nxt;
        if (pl.gl != 5'd0 && pl.og + 5'd1 <= nx)  r.group_symbol       = grp_nxt;
        r.bytes_consumed = FIXED_LEN + start;
      end
    end else begin
      hit = 1'b0;
    end

    // flag bits only on results past the fixed header
    if (hit && n >= FIXED_LEN && !(n == idl2)) begin
      if (lay == VER_23) begin
        r.tag_alter  = flag_nxt[15];
        r.file_alter = flag_nxt[14];
        r.read_only  = flag_nxt[13];
      end else if (lay == VER_24) begin
        r.tag_alter  = flag_nxt[14];
        r.file_alter = flag_nxt[13];
        r.read_only  = flag_nxt[12];
        r.unsync     = flag_nxt[1];
      end
    end
  end

  assign res_valid = fire & ~done0 & hit;
  assign res       = r;
  assign stat      = '{byte_pos: pos_r, done: done_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ver_r  <= VER_RESET;
      lay_r  <= VER_RESET;
      pos_r  <= 5'd0;
      done_r <= 1'b1;
    end else begin
      if (cfg_wr_en) begin
        ver_r <= cfg_wr_data;
      end
      if (fire) begin
        lay_r  <= lay;
        pos_r  <= done0 ? pos0 : n;
        done_r <= done0 | hit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      if (done0) begin
        id_r   <= id0;
        size_r <= size0;
        flag_r <= flag0;
        opt_r  <= opt0;
        enc_r  <= enc0;
        grp_r  <= grp0;
      end else begin
        id_r   <= id_nxt;
        size_r <= size_nxt;
        flag_r <= flag_nxt;
        opt_r  <= opt_nxt;
        enc_r  <= enc_nxt;
        grp_r  <= grp_nxt;
      end
    end
  end

endmodule

`default_nettype wire

// ----- hdl/id3fh_out_stage.sv -----
// ----------------------------------------------------------------------------
// id3fh_out_stage
// Result register; holds a result until the receiver takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module id3fh_out_stage
  import id3fh_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    res_valid,
  input  wire result_t res,
  input  wire logic    out_stall,
  output logic         out_valid,
  output result_t      out_res,
  output logic         adv
);

  logic    out_valid_r;
  result_t out_res_r;

  assign adv       = ~out_valid_r | ~out_stall;
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_res_r <= res;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/id3v2_frame_header_parser.sv -----
// ----------------------------------------------------------------------------
// id3v2_frame_header_parser
// ID3v2.2/2.3/2.4 frame header parser, one header byte per request.
//
//   channel  dir  handshake            payload
//   in_      in   in_valid/in_stall    data_byte, start_of_header, buffer_end
//   out_     out  out_valid/out_stall  id, size, flags, optional fields, status
//   cfg_     in   cfg_wr_en            tag_version (3 bits)
//
// One byte per cycle sustained while out_stall is low; a byte passes through the input
// register and then the result register before its result appears.
// Reset is synchronous; no clearing pass. Version resets to 3.
// An out_stall with a held result stalls the input only when a byte waits.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module id3v2_frame_header_parser
  import id3fh_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic [2:0]  cfg_wr_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic        in_start_of_header,
  input  wire logic        in_buffer_end,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      out_frame_id,
  output logic [31:0]      out_content_size,
  output logic             out_tag_alter,
  output logic             out_file_alter,
  output logic             out_read_only,
  output logic             out_unsync,
  output logic [31:0]      out_decompression_size,
  output logic [7:0]       out_encryption_symbol,
  output logic [7:0]       out_group_symbol,
  output logic [4:0]       out_bytes_consumed,
  output logic [2:0]       out_status
);

  item_t      in_item, s1_item;
  logic       s1_valid, adv, fire, res_valid;
  result_t    res, out_res;
  core_stat_t stat;

  assign in_item = '{data_byte: in_data_byte, start_of_header: in_start_of_header,
                     buffer_end: in_buffer_end};
  assign fire    = s1_valid & adv;

  id3fh_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .adv      (adv),
    .s1_valid (s1_valid),
    .s1_item  (s1_item)
  );

  id3fh_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .fire        (fire),
    .item        (s1_item),
    .res_valid   (res_valid),
    .res         (res),
    .stat        (stat)
  );

  id3fh_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res       (res),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_res   (out_res),
    .adv       (adv)
  );

  assign out_frame_id           = out_res.frame_id;
  assign out_content_size       = out_res.content_size;
  assign out_tag_alter          = out_res.tag_alter;
  assign out_file_alter         = out_res.file_alter;
  assign out_read_only          = out_res.read_only;
  assign out_unsync             = out_res.unsync;
  assign out_decompression_size = out_res.decompression_size;
  assign out_encryption_symbol  = out_res.encryption_symbol;
  assign out_group_symbol       = out_res.group_symbol;
  assign out_bytes_consumed     = out_res.bytes_consumed;
  assign out_status             = out_res.status;

  `CHK_IMPLY(a_res_slot_free, res_valid, !out_valid || !out_stall, "result over held result")
  `CHK_ALWAYS(a_pos_bound, stat.byte_pos <= MAX_HDR_LEN, "byte position past header end")
  `CHK_IMPLY(a_active_pos, !stat.done, stat.byte_pos != 5'd0, "active parse with no bytes")
  `CHK_IMPLY(a_ok_len, out_valid && out_status == ST_OK, out_bytes_consumed >= 5'd6, "short ok")

endmodule

`default_nettype wire
